@@ hdl/rcm_pkg.sv @@
package rcm_pkg;

    // Default sizes of the pattern stores
    localparam int MAX_NODES_DEF = 1024;
    localparam int MAX_EDGES_DEF = 8192;

    // Field widths on the streams
    localparam int ACTION_W   = 2;
    localparam int ADDR_W     = 13;
    localparam int VALUE_W    = 14;
    localparam int RDATA_W    = 10;
    localparam int NODE_OUT_W = 10;
    localparam int LEVEL_W    = 11;
    localparam int STATUS_W   = 2;
    localparam int CFG_W      = 11;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 40;
    localparam int M_PAD_W    = M_DATA_W - RDATA_W - NODE_OUT_W - LEVEL_W - STATUS_W;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WR_PTR = 2'd0,
        ACT_WR_COL = 2'd1,
        ACT_RUN    = 2'd2,
        ACT_READ   = 2'd3
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK           = 2'd0,
        STATUS_DISCONNECTED = 2'd1,
        STATUS_RANGE        = 2'd2
    } status_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_READ,
        ST_CLEAR,
        ST_INIT,
        ST_LEVEL,
        ST_HEAD,
        ST_NODE,
        ST_BEGIN,
        ST_END,
        ST_EDGE,
        ST_NEIGH,
        ST_MARK,
        ST_WALK_DONE,
        ST_PICK_RD,
        ST_PICK_NODE,
        ST_PICK_BEGIN,
        ST_PICK_END,
        ST_NUM_RD,
        ST_NUM_WR,
        ST_FINISH
    } state_t;

    // Which walk of a run is in progress
    typedef enum logic [1:0] {
        PH_FIRST,
        PH_CAND,
        PH_FINAL
    } phase_t;

endpackage

@@ hdl/rcm_ram.sv @@
module rcm_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ hdl/rcm_graph_ordering.sv @@
// Reverse Cuthill-McKee ordering engine. Load the symmetric pattern as row
// pointers and column indices, issue a run, then read back the new index of
// each node. Pointer and column writes and out-of-range reads register their
// item directly; an in-range read passes the READ state first. A run is a
// sequence of breadth-first walks on memories with one write port and one
// registered read port: each walk clears all visited marks, then steps through
// HEAD, NODE, BEGIN, END and EDGE per node, LEVEL and HEAD per level, and EDGE
// and NEIGH per stored neighbor (plus MARK if in range); the peripheral search
// steps through PICK_RD to PICK_END per last-level node, the final numbering
// through NUM_RD and NUM_WR per node. No item is taken while a run is busy.
// The user must write node_count only while nothing is in flight; the block does not enforce it.
// A disconnected graph ends the run with status 1 and the table unchanged.
module rcm_graph_ordering
    import rcm_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF,
    parameter int MAX_EDGES = MAX_EDGES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration: node_count
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_W-1:0]    cfg_data,
    // input items
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // action[1:0], address[14:2], value[28:15]
    // result items
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // read_data[9:0], peripheral_node[19:10],
                                           // level_count[30:20], status[32:31]
);

    localparam int NODE_AW = $clog2(MAX_NODES);
    localparam int RP_AW   = $clog2(MAX_NODES + 1);
    localparam int CNT_W   = $clog2(MAX_NODES + 1);
    localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int PTR_W   = $clog2(MAX_EDGES + 1);

    // Input fields
    action_t            in_action;
    logic [ADDR_W-1:0]  in_address;
    logic [VALUE_W-1:0] in_value;
    logic               s_accept;

    assign in_action  = action_t'(s_tdata[1:0]);
    assign in_address = s_tdata[14:2];
    assign in_value   = s_tdata[28:15];
    assign s_accept   = s_tvalid && s_tready;

    // Registers
    state_t               state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic [CNT_W-1:0]     n_reg, n_next;
    logic                 m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]  m_data_reg, m_data_next;
    logic [NODE_AW-1:0]   best_node_reg, best_node_next;
    logic [CNT_W-1:0]     best_lv_reg, best_lv_next;
    status_t              last_status_reg, last_status_next;
    logic                 walk_ok_reg, walk_ok_next;
    logic                 first_reg, first_next;
    logic [NODE_AW-1:0]   start_reg, start_next;
    logic [NODE_AW-1:0]   chosen_reg, chosen_next;
    logic [CNT_W-1:0]     chosen_lv_reg, chosen_lv_next;
    logic [NODE_AW-1:0]   cand_reg, cand_next;
    logic [PTR_W-1:0]     best_deg_reg, best_deg_next;
    logic [CNT_W-1:0]     k_reg, k_next;
    logic [CNT_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     tail_reg, tail_next;
    logic [CNT_W-1:0]     lb_reg, lb_next;
    logic [CNT_W-1:0]     le_reg, le_next;
    logic [CNT_W-1:0]     lv_reg, lv_next;
    logic [NODE_AW-1:0]   u_reg, u_next;
    logic [NODE_AW-1:0]   v_reg, v_next;
    logic [PTR_W-1:0]     j_reg, j_next;
    logic [PTR_W-1:0]     e_reg, e_next;

    // Memory ports
    logic                 rp_we;
    logic [RP_AW-1:0]     rp_waddr, rp_raddr;
    logic [VALUE_W-1:0]   rp_wdata, rp_rdata;
    logic                 col_we;
    logic [EDGE_AW-1:0]   col_waddr, col_raddr;
    logic [VALUE_W-1:0]   col_wdata, col_rdata;
    logic                 vis_we;
    logic [NODE_AW-1:0]   vis_waddr, vis_raddr;
    logic                 vis_wdata, vis_rdata;
    logic                 vo_we;
    logic [NODE_AW-1:0]   vo_waddr, vo_raddr;
    logic [NODE_AW-1:0]   vo_wdata, vo_rdata;
    logic                 ni_we;
    logic [NODE_AW-1:0]   ni_waddr, ni_raddr;
    logic [NODE_AW-1:0]   ni_wdata, ni_rdata;

    rcm_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_NODES + 1)) u_row_ptr (
        .aclk(aclk), .wr_en(rp_we), .wr_addr(rp_waddr), .wr_data(rp_wdata),
        .rd_addr(rp_raddr), .rd_data(rp_rdata)
    );

    rcm_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_EDGES)) u_col_idx (
        .aclk(aclk), .wr_en(col_we), .wr_addr(col_waddr), .wr_data(col_wdata),
        .rd_addr(col_raddr), .rd_data(col_rdata)
    );

    rcm_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_visited (
        .aclk(aclk), .wr_en(vis_we), .wr_addr(vis_waddr), .wr_data(vis_wdata),
        .rd_addr(vis_raddr), .rd_data(vis_rdata)
    );

    rcm_ram #(.WIDTH(NODE_AW), .DEPTH(MAX_NODES)) u_visit_order (
        .aclk(aclk), .wr_en(vo_we), .wr_addr(vo_waddr), .wr_data(vo_wdata),
        .rd_addr(vo_raddr), .rd_data(vo_rdata)
    );

    rcm_ram #(.WIDTH(NODE_AW), .DEPTH(MAX_NODES)) u_new_index (
        .aclk(aclk), .wr_en(ni_we), .wr_addr(ni_waddr), .wr_data(ni_wdata),
        .rd_addr(ni_raddr), .rd_data(ni_rdata)
    );

    // Clamped row pointer and degree
    logic [PTR_W-1:0]     ptr_clamped;
    logic [PTR_W-1:0]     degree;
    logic                 neigh_in_range;
    logic                 wr_ptr_ok, wr_col_ok, rd_ok;

    assign ptr_clamped    = (32'(rp_rdata) > 32'(MAX_EDGES)) ? PTR_W'(MAX_EDGES)
                                                             : PTR_W'(rp_rdata);
    assign degree         = (ptr_clamped > j_reg) ? (ptr_clamped - j_reg) : '0;
    assign neigh_in_range = 32'(col_rdata) < 32'(n_reg);
    assign wr_ptr_ok      = 32'(in_address) <= 32'(MAX_NODES);
    assign wr_col_ok      = 32'(in_address) < 32'(MAX_EDGES);
    assign rd_ok          = 32'(in_address) < 32'(n_reg);

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Result word
    function automatic logic [M_DATA_W-1:0] pack_result(
        input logic [RDATA_W-1:0]    rd,
        input logic [NODE_OUT_W-1:0] node,
        input logic [LEVEL_W-1:0]    lvl,
        input status_t               st
    );
        return {{M_PAD_W{1'b0}}, st, lvl, node, rd};
    endfunction

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && in_action == ACT_RUN) begin
                    state_next = ST_CLEAR;
                end else if (s_accept && in_action == ACT_READ && rd_ok) begin
                    state_next = ST_READ;
                end
            end
            ST_READ:  state_next = ST_IDLE;
            ST_CLEAR: begin
                if (k_reg + 1'b1 >= n_reg) begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:  state_next = ST_LEVEL;
            ST_LEVEL: state_next = (tail_reg >= n_reg) ? ST_WALK_DONE : ST_HEAD;
            ST_HEAD: begin
                if (head_reg < le_reg) begin
                    state_next = ST_NODE;
                end else if (tail_reg == le_reg) begin
                    state_next = ST_WALK_DONE;
                end else begin
                    state_next = ST_LEVEL;
                end
            end
            ST_NODE:  state_next = ST_BEGIN;
            ST_BEGIN: state_next = ST_END;
            ST_END:   state_next = ST_EDGE;
            ST_EDGE:  state_next = (j_reg < e_reg) ? ST_NEIGH : ST_HEAD;
            ST_NEIGH: state_next = neigh_in_range ? ST_MARK : ST_EDGE;
            ST_MARK:  state_next = ST_EDGE;
            ST_WALK_DONE: begin
                if (!walk_ok_reg) begin
                    state_next = ST_FINISH;
                end else begin
                    unique case (phase_reg)
                        PH_FIRST: state_next = ST_PICK_RD;
                        PH_CAND:  state_next = (lv_reg <= chosen_lv_reg) ? ST_CLEAR
                                                                         : ST_PICK_RD;
                        PH_FINAL: state_next = ST_NUM_RD;
                        default:  state_next = ST_FINISH;
                    endcase
                end
            end
            ST_PICK_RD:    state_next = ST_PICK_NODE;
            ST_PICK_NODE:  state_next = ST_PICK_BEGIN;
            ST_PICK_BEGIN: state_next = ST_PICK_END;
            ST_PICK_END:   state_next = (k_reg + 1'b1 < n_reg) ? ST_PICK_RD : ST_CLEAR;
            ST_NUM_RD:     state_next = ST_NUM_WR;
            ST_NUM_WR:     state_next = (k_reg + 1'b1 < n_reg) ? ST_NUM_RD : ST_FINISH;
            ST_FINISH:     state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control
    always_comb begin
        phase_next       = phase_reg;
        n_next           = n_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_data_next      = m_data_reg;
        best_node_next   = best_node_reg;
        best_lv_next     = best_lv_reg;
        last_status_next = last_status_reg;
        walk_ok_next     = walk_ok_reg;
        first_next       = first_reg;
        start_next       = start_reg;
        chosen_next      = chosen_reg;
        chosen_lv_next   = chosen_lv_reg;
        cand_next        = cand_reg;
        best_deg_next    = best_deg_reg;
        k_next           = k_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        lb_next          = lb_reg;
        le_next          = le_reg;
        lv_next          = lv_reg;
        u_next           = u_reg;
        v_next           = v_reg;
        j_next           = j_reg;
        e_next           = e_reg;

        rp_we     = 1'b0;
        rp_waddr  = RP_AW'(in_address);
        rp_wdata  = in_value;
        rp_raddr  = RP_AW'(u_reg);
        col_we    = 1'b0;
        col_waddr = EDGE_AW'(in_address);
        col_wdata = in_value;
        col_raddr = EDGE_AW'(j_reg);
        vis_we    = 1'b0;
        vis_waddr = NODE_AW'(k_reg);
        vis_wdata = 1'b0;
        vis_raddr = NODE_AW'(col_rdata);
        vo_we     = 1'b0;
        vo_waddr  = NODE_AW'(tail_reg);
        vo_wdata  = v_reg;
        vo_raddr  = NODE_AW'(head_reg);
        ni_we     = 1'b0;
        ni_waddr  = vo_rdata;
        ni_wdata  = NODE_AW'(n_reg - 1'b1 - k_reg);
        ni_raddr  = NODE_AW'(in_address);

        // node_count write, clamped into range
        if (cfg_valid) begin
            if (cfg_data == '0) begin
                n_next = CNT_W'(1);
            end else if (32'(cfg_data) > 32'(MAX_NODES)) begin
                n_next = CNT_W'(MAX_NODES);
            end else begin
                n_next = CNT_W'(cfg_data);
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    unique case (in_action)
                        ACT_WR_PTR: begin
                            rp_we        = wr_ptr_ok;
                            m_valid_next = 1'b1;
                            m_data_next  = pack_result('0, NODE_OUT_W'(best_node_reg),
                                LEVEL_W'(best_lv_reg),
                                wr_ptr_ok ? last_status_reg : STATUS_RANGE);
                        end
                        ACT_WR_COL: begin
                            col_we       = wr_col_ok;
                            m_valid_next = 1'b1;
                            m_data_next  = pack_result('0, NODE_OUT_W'(best_node_reg),
                                LEVEL_W'(best_lv_reg),
                                wr_col_ok ? last_status_reg : STATUS_RANGE);
                        end
                        ACT_RUN: begin
                            phase_next = PH_FIRST;
                            start_next = '0;
                            k_next     = '0;
                        end
                        ACT_READ: begin
                            if (!rd_ok) begin
                                m_valid_next = 1'b1;
                                m_data_next  = pack_result('0, NODE_OUT_W'(best_node_reg),
                                    LEVEL_W'(best_lv_reg), STATUS_RANGE);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                m_valid_next = 1'b1;
                m_data_next  = pack_result(RDATA_W'(ni_rdata), NODE_OUT_W'(best_node_reg),
                    LEVEL_W'(best_lv_reg), last_status_reg);
            end
            // Walk: clear marks, seed with the start node
            ST_CLEAR: begin
                vis_we    = 1'b1;
                vis_waddr = NODE_AW'(k_reg);
                vis_wdata = 1'b0;
                k_next    = k_reg + 1'b1;
            end
            ST_INIT: begin
                vis_we    = 1'b1;
                vis_waddr = start_reg;
                vis_wdata = 1'b1;
                vo_we     = 1'b1;
                vo_waddr  = '0;
                vo_wdata  = start_reg;
                tail_next = CNT_W'(1);
                lb_next   = '0;
                le_next   = CNT_W'(1);
                lv_next   = CNT_W'(1);
            end
            ST_LEVEL: begin
                head_next = lb_reg;
                if (tail_reg >= n_reg) begin
                    walk_ok_next = 1'b1;
                end
            end
            ST_HEAD: begin
                vo_raddr = NODE_AW'(head_reg);
                if (head_reg >= le_reg) begin
                    if (tail_reg == le_reg) begin
                        walk_ok_next = 1'b0;
                    end else begin
                        lb_next = le_reg;
                        le_next = tail_reg;
                        lv_next = lv_reg + 1'b1;
                    end
                end
            end
            ST_NODE: begin
                u_next   = vo_rdata;
                rp_raddr = RP_AW'(vo_rdata);
            end
            ST_BEGIN: begin
                j_next   = ptr_clamped;
                rp_raddr = RP_AW'(u_reg) + 1'b1;
            end
            ST_END: begin
                e_next = ptr_clamped;
            end
            ST_EDGE: begin
                col_raddr = EDGE_AW'(j_reg);
                if (j_reg >= e_reg) begin
                    head_next = head_reg + 1'b1;
                end
            end
            ST_NEIGH: begin
                v_next    = NODE_AW'(col_rdata);
                vis_raddr = NODE_AW'(col_rdata);
                if (!neigh_in_range) begin
                    j_next = j_reg + 1'b1;
                end
            end
            ST_MARK: begin
                if (!vis_rdata) begin
                    vis_we    = 1'b1;
                    vis_waddr = v_reg;
                    vis_wdata = 1'b1;
                    vo_we     = 1'b1;
                    vo_waddr  = NODE_AW'(tail_reg);
                    vo_wdata  = v_reg;
                    tail_next = tail_reg + 1'b1;
                end
                j_next = j_reg + 1'b1;
            end
            // Walk outcome drives the peripheral search
            ST_WALK_DONE: begin
                k_next     = lb_reg;
                first_next = 1'b1;
                if (!walk_ok_reg) begin
                    best_node_next   = start_reg;
                    best_lv_next     = lv_reg;
                    last_status_next = STATUS_DISCONNECTED;
                end else begin
                    unique case (phase_reg)
                        PH_FIRST: begin
                            chosen_next    = start_reg;
                            chosen_lv_next = lv_reg;
                            phase_next     = PH_CAND;
                        end
                        PH_CAND: begin
                            if (lv_reg <= chosen_lv_reg) begin
                                phase_next = PH_FINAL;
                                start_next = chosen_reg;
                                k_next     = '0;
                            end else begin
                                chosen_next    = start_reg;
                                chosen_lv_next = lv_reg;
                            end
                        end
                        PH_FINAL: begin
                            k_next = '0;
                        end
                        default: ;
                    endcase
                end
            end
            // Smallest degree in the last level, first one wins a tie
            ST_PICK_RD: begin
                vo_raddr = NODE_AW'(k_reg);
            end
            ST_PICK_NODE: begin
                u_next   = vo_rdata;
                rp_raddr = RP_AW'(vo_rdata);
            end
            ST_PICK_BEGIN: begin
                j_next   = ptr_clamped;
                rp_raddr = RP_AW'(u_reg) + 1'b1;
            end
            ST_PICK_END: begin
                first_next = 1'b0;
                if (first_reg || degree < best_deg_reg) begin
                    best_deg_next = degree;
                    cand_next     = u_reg;
                end
                k_next = k_reg + 1'b1;
                if (k_reg + 1'b1 >= n_reg) begin
                    start_next = (first_reg || degree < best_deg_reg) ? u_reg : cand_reg;
                    k_next     = '0;
                end
            end
            // Reverse visiting order numbering
            ST_NUM_RD: begin
                vo_raddr = NODE_AW'(k_reg);
            end
            ST_NUM_WR: begin
                ni_we    = 1'b1;
                ni_waddr = vo_rdata;
                ni_wdata = NODE_AW'(n_reg - 1'b1 - k_reg);
                k_next   = k_reg + 1'b1;
                if (k_reg + 1'b1 >= n_reg) begin
                    best_node_next   = chosen_reg;
                    best_lv_next     = chosen_lv_reg;
                    last_status_next = STATUS_OK;
                end
            end
            ST_FINISH: begin
                m_valid_next = 1'b1;
                m_data_next  = pack_result('0, NODE_OUT_W'(best_node_reg),
                    LEVEL_W'(best_lv_reg), last_status_reg);
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            n_reg           <= CNT_W'(1);
            best_node_reg   <= '0;
            best_lv_reg     <= '0;
            last_status_reg <= STATUS_OK;
        end else begin
            state_reg       <= state_next;
            m_valid_reg     <= m_valid_next;
            n_reg           <= n_next;
            best_node_reg   <= best_node_next;
            best_lv_reg     <= best_lv_next;
            last_status_reg <= last_status_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        phase_reg     <= phase_next;
        m_data_reg    <= m_data_next;
        walk_ok_reg   <= walk_ok_next;
        first_reg     <= first_next;
        start_reg     <= start_next;
        chosen_reg    <= chosen_next;
        chosen_lv_reg <= chosen_lv_next;
        cand_reg      <= cand_next;
        best_deg_reg  <= best_deg_next;
        k_reg         <= k_next;
        head_reg      <= head_next;
        tail_reg      <= tail_next;
        lb_reg        <= lb_next;
        le_reg        <= le_next;
        lv_reg        <= lv_next;
        u_reg         <= u_next;
        v_reg         <= v_next;
        j_reg         <= j_next;
        e_reg         <= e_next;
    end

    // Checks
    a_ready_only_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == ST_IDLE)
        else $error("input ready outside idle");

    a_run_starts_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && in_action == ACT_RUN) |=> state_reg == ST_CLEAR)
        else $error("run did not start with clearing pass");

    a_tail_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EDGE || state_reg == ST_MARK) |-> tail_reg <= n_reg)
        else $error("visit queue overran node count");

    a_status_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        last_status_reg != STATUS_RANGE)
        else $error("range error stored as run status");

    a_finish_out: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FINISH |=> m_valid_reg)
        else $error("run finished without result");

endmodule
